/* rtl/smpq_pkg.sv */
package smpq_pkg;

   localparam int PRIO_WIDTH = 16;
   localparam int OCC_WIDTH  = 7;
   localparam int STAT_WIDTH = 2;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   localparam logic [STAT_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_WIDTH-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_WIDTH-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                         op;
      logic signed [PRIO_WIDTH-1:0] priority_in;
   } smpq_req_type;

   typedef struct packed {
      logic signed [PRIO_WIDTH-1:0] value_out;
      logic [STAT_WIDTH-1:0]        status;
      logic [OCC_WIDTH-1:0]         occupancy;
   } smpq_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_READ,
      ST_INS_CMP,
      ST_EXT_READ,
      ST_EXT_POP,
      ST_DONE
   } smpq_state_type;

   typedef struct packed {
      logic load_item;
      logic rd_issue;
      logic rd_head;
      logic shift_write;
      logic place_write;
      logic pop;
      logic rsp_load;
   } smpq_cmd_type;

   typedef struct packed {
      logic item_extract;
      logic rejected;
      logic pos_zero;
      logic greater;
      logic rsp_free;
   } smpq_stat_type;

endpackage

/* rtl/sorted_min_priority_queue.sv */
// Sorted minimum priority queue: holds up to DEPTH signed 16-bit priorities in
// ascending order in a single-port circular buffer, so the smallest value always
// sits at the head pointer. An extract reads the head and advances it. An insert
// walks down from the tail, moving each larger value up one place with a read
// and a write, then drops the new value into the gap, so its walk over the
// memory port grows with the number of larger values held. A new request is
// taken only once the previous one has finished. An insert into a full queue
// is dropped with status 1, an extract from an empty queue returns zero with
// status 2. Every request beat yields exactly one response beat, and occupancy
// reports the count after the operation (lowest 7 bits). A finished response
// waits in an output register, so the next request is taken while it is still
// pending. The store needs no clearing after reset.
module sorted_min_priority_queue
   import smpq_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  smpq_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output smpq_rsp_type rsp_data
);

   // command and status between sequencer and datapath
   smpq_cmd_type  cmd;
   smpq_stat_type stat;

   // sequence each beat: dispatch, walk or pop, then hand over the result
   smpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold the sorted entries, head, count and the response register
   smpq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

/* rtl/smpq_ctrl.sv */
module smpq_ctrl
   import smpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  smpq_stat_type stat,
   output smpq_cmd_type  cmd
);

   smpq_state_type state_ff;
   smpq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (stat.rejected) begin
               state_in = ST_DONE;
            end else if (stat.item_extract) begin
               state_in = ST_EXT_READ;
            end else begin
               state_in = ST_INS_READ;
            end
         end
         ST_INS_READ: begin
            state_in = stat.pos_zero ? ST_DONE : ST_INS_CMP;
         end
         ST_INS_CMP: begin
            state_in = stat.greater ? ST_INS_READ : ST_DONE;
         end
         ST_EXT_READ: state_in = ST_EXT_POP;
         ST_EXT_POP:  state_in = ST_DONE;
         ST_DONE: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_DISPATCH: ;
         ST_INS_READ: begin
            // place at the bottom, or fetch the neighbour below
            cmd.place_write = stat.pos_zero;
            cmd.rd_issue    = !stat.pos_zero;
         end
         ST_INS_CMP: begin
            cmd.shift_write = stat.greater;
            cmd.place_write = !stat.greater;
         end
         ST_EXT_READ: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_head  = 1'b1;
         end
         ST_EXT_POP: cmd.pop = 1'b1;
         ST_DONE:    cmd.rsp_load = stat.rsp_free;
         default: ;
      endcase
   end

endmodule

/* rtl/smpq_datapath.sv */
module smpq_datapath
   import smpq_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic          clock,
   input  logic          reset,
   input  smpq_req_type  req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output smpq_rsp_type  rsp_data,
   input  smpq_cmd_type  cmd,
   output smpq_stat_type stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [AW-1:0] wrap_addr(input logic [AW:0] sum);
      logic [AW:0] lim;
      lim = (AW+1)'(DEPTH);
      if (sum >= lim) begin
         return AW'(sum - lim);
      end
      return AW'(sum);
   endfunction

   logic [PRIO_WIDTH-1:0] entries_ff [DEPTH];
   logic [PRIO_WIDTH-1:0] rd_data_ff;

   logic [AW-1:0]               head_ff, head_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               pos_ff, pos_in;
   logic                        item_op_ff, item_op_in;
   logic signed [PRIO_WIDTH-1:0] item_prio_ff, item_prio_in;
   logic signed [PRIO_WIDTH-1:0] res_value_ff, res_value_in;
   logic [STAT_WIDTH-1:0]       res_status_ff, res_status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   smpq_rsp_type                rsp_data_ff, rsp_data_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [PRIO_WIDTH-1:0] mem_wdata;
   logic [AW-1:0]         rd_addr;

   always_comb begin
      item_op_in    = item_op_ff;
      item_prio_in  = item_prio_ff;
      pos_in        = pos_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = wrap_addr({1'b0, head_ff} + (AW+1)'(pos_ff));
      mem_wdata     = rd_data_ff;

      if (cmd.rd_head) begin
         rd_addr = head_ff;
      end else begin
         rd_addr = wrap_addr({1'b0, head_ff} + (AW+1)'(pos_ff - CW'(1)));
      end

      if (cmd.load_item) begin
         item_op_in   = req_data.op;
         item_prio_in = req_data.priority_in;
         pos_in       = count_ff;
         res_value_in = '0;
         if (req_data.op == OP_INSERT && count_ff == CW'(DEPTH)) begin
            res_status_in = STATUS_FULL;
         end else if (req_data.op == OP_EXTRACT && count_ff == '0) begin
            res_status_in = STATUS_EMPTY;
         end else begin
            res_status_in = STATUS_OK;
         end
      end
      if (cmd.shift_write) begin
         mem_we = 1'b1;
         pos_in = pos_ff - CW'(1);
      end
      if (cmd.place_write) begin
         mem_we    = 1'b1;
         mem_wdata = item_prio_ff;
         count_in  = count_ff + CW'(1);
      end
      if (cmd.pop) begin
         res_value_in = rd_data_ff;
         head_in      = wrap_addr({1'b0, head_ff} + (AW+1)'(1));
         count_in     = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.value_out = res_value_ff;
         rsp_data_in.status    = res_status_ff;
         rsp_data_in.occupancy = OCC_WIDTH'(count_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) entries_ff[mem_waddr] <= mem_wdata;
      if (cmd.rd_issue) rd_data_ff <= entries_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      item_op_ff    <= item_op_in;
      item_prio_ff  <= item_prio_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      stat.item_extract = (item_op_ff == OP_EXTRACT);
      stat.rejected     = (res_status_ff != STATUS_OK);
      stat.pos_zero     = (pos_ff == '0);
      stat.greater      = ($signed(rd_data_ff) > item_prio_ff);
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond capacity");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

   a_place_count: assert property (@(posedge clock) disable iff (reset)
      cmd.place_write |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not raise the count");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != STATUS_OK) |-> rsp_data_ff.value_out == '0)
      else $error("rejected operation returned a value");

endmodule

/* tb/sv/sorted_min_priority_queue_tb.sv */
`timescale 1ns / 1ps

module sorted_min_priority_queue_tb
   import smpq_pkg::*;
();

   localparam int QUEUE_DEPTH  = 64;
   localparam int ITEM_TARGET  = 1900;
   localparam int FILL_BURST   = QUEUE_DEPTH + 6;
   // Allows for the longest insert, which walks the whole store, plus some margin.
   localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 20;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int IDLE_PCT     = 9;
   localparam int HOLD_AT_BEAT = 400;
   localparam int HOLD_CYCLES  = 600;
   localparam int CALM_FROM    = 900;
   localparam int CALM_TO      = 1200;

   localparam logic signed [PRIO_WIDTH-1:0] PRIO_MAX = 16'sh7FFF;
   localparam logic signed [PRIO_WIDTH-1:0] PRIO_MIN = 16'sh8000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   smpq_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   smpq_rsp_type rsp_data;

   // Beats waiting to be offered, results still owed, and the predicted
   // contents of the queue in ascending order.
   smpq_req_type                 pending_reqs[$];
   smpq_rsp_type                 owed_results[$];
   logic signed [PRIO_WIDTH-1:0] shadow_prios[$];

   int unsigned beats_in   = 0;
   int unsigned beats_out  = 0;
   int unsigned hold_left  = 0;
   logic        hold_done  = 1'b0;
   logic        req_taken  = 1'b0;
   int unsigned mismatches = 0;
   int unsigned cycles     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sorted_min_priority_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Apply one operation to the shadow queue and return the result it owes.
   // Equal values land after the ones already held; their order is invisible.
   function automatic smpq_rsp_type sorted_queue_step(smpq_req_type req);
      smpq_rsp_type res;
      int           pos;
      res = '0;
      res.status = STATUS_OK;
      if (req.op == OP_INSERT) begin
         if (shadow_prios.size() >= QUEUE_DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_prios.size() &&
                   shadow_prios[pos] <= $signed(req.priority_in)) begin
               pos++;
            end
            shadow_prios.insert(pos, req.priority_in);
         end
      end else begin
         if (shadow_prios.size() == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.value_out = shadow_prios.pop_front();
         end
      end
      res.occupancy = OCC_WIDTH'(shadow_prios.size());
      return res;
   endfunction

   // Mostly full-range values, with extremes and a narrow band for duplicates.
   function automatic logic signed [PRIO_WIDTH-1:0] random_prio();
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, 1) ? PRIO_MAX : PRIO_MIN;
         1, 2:    return PRIO_WIDTH'($urandom_range(0, 8) - 4);
         default: return PRIO_WIDTH'($urandom);
      endcase
   endfunction

   function automatic void queue_req(logic op, logic signed [PRIO_WIDTH-1:0] prio);
      smpq_req_type item;
      item.op          = op;
      item.priority_in = prio;
      pending_reqs.push_back(item);
   endfunction

   // Hold until every beat has been taken and every result has come back.
   task automatic wait_for_drain();
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (owed_results.size() != 0) @(posedge clock);
   endtask

   // Request side, sampled: predict the result of each accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            owed_results.push_back(sorted_queue_step(req_data));
            beats_in <= beats_in + 1;
         end
      end
   end

   // Request side, driven: hold an unaccepted beat, otherwise offer the next
   // one unless this cycle idles. No idling inside the calm window.
   always @(negedge clock) begin
      logic calm;
      calm = beats_in >= CALM_FROM && beats_in < CALM_TO;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (pending_reqs.size() != 0 &&
                   (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
         req_data  <= pending_reqs.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Response side, driven: one long hold-off so the block backs up and
   // stalls its input, random stalls elsewhere, none inside the calm window.
   always @(negedge clock) begin
      logic calm;
      calm = beats_out >= CALM_FROM && beats_out < CALM_TO;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && beats_out >= HOLD_AT_BEAT) begin
         rsp_ready <= 1'b0;
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   // Response side, sampled: compare each beat with the oldest result owed.
   always @(posedge clock) begin
      smpq_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out <= beats_out + 1;
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, got value %0d status %0d occ %0d",
                     $time, rsp_data.value_out, rsp_data.status, rsp_data.occupancy);
            mismatches++;
         end else begin
            want = owed_results.pop_front();
            if (rsp_data.value_out !== want.value_out) begin
               $display("%0t: value_out mismatch, expected %0d, got %0d",
                        $time, want.value_out, rsp_data.value_out);
               mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.occupancy !== want.occupancy) begin
               $display("%0t: occupancy mismatch, expected %0d, got %0d",
                        $time, want.occupancy, rsp_data.occupancy);
               mismatches++;
            end
         end
      end
   end

   // Guard against a hang anywhere in the run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int unsigned made;
      int unsigned phase_len;
      int unsigned insert_pct;
      int unsigned i;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: extract from empty, both extremes, zero and its neighbours,
      // a duplicate, alternating bit patterns, then drain past empty.
      queue_req(OP_EXTRACT, PRIO_MAX);
      queue_req(OP_INSERT, 16'sd0);
      queue_req(OP_INSERT, PRIO_MIN);
      queue_req(OP_INSERT, PRIO_MAX);
      queue_req(OP_INSERT, -16'sd1);
      queue_req(OP_INSERT, 16'sd1);
      queue_req(OP_INSERT, -16'sd1);
      queue_req(OP_INSERT, 16'sh5555);
      queue_req(OP_INSERT, 16'shAAAA);
      for (i = 0; i < 9; i++) queue_req(OP_EXTRACT, random_prio());
      queue_req(OP_INSERT, 16'sd7);
      queue_req(OP_EXTRACT, PRIO_MIN);

      // Pause the sender until the directed part has fully come back.
      wait_for_drain();

      // Fill past capacity so inserts into a full queue are dropped.
      for (i = 0; i < FILL_BURST; i++) queue_req(OP_INSERT, random_prio());

      // Phases biased towards filling, draining or neither, so the queue
      // swings between full and empty with random contents.
      made = 0;
      while (made < ITEM_TARGET) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
         endcase
         phase_len = $urandom_range(30, 150);
         if (phase_len > ITEM_TARGET - made) phase_len = ITEM_TARGET - made;
         for (i = 0; i < phase_len; i++) begin
            queue_req($urandom_range(0, 99) < insert_pct ? OP_INSERT : OP_EXTRACT,
                      random_prio());
         end
         made += phase_len;
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
